// File: rtl/ltte_pkg.sv
`timescale 1ns / 1ps
package ltte_pkg;

    localparam int MAX_BEAMS_DEF   = 4096;
    localparam int TRIG_DEPTH_DEF  = 1024;

    // angles in units of 2^-16 rad
    localparam longint HALF_PI_U   = 102944;
    localparam longint PI_U        = 2 * HALF_PI_U;
    localparam longint TWO_PI_U    = 4 * HALF_PI_U;
    localparam longint HALF_PI_Q30 = 1686629713;

    // reciprocal constants for division by a constant
    localparam int     RECIP_SHIFT = 48;
    localparam longint RECIP_TWO_PI  = (64'sd1 <<< RECIP_SHIFT) / TWO_PI_U;
    localparam longint RECIP_HALF_PI = (64'sd1 <<< RECIP_SHIFT) / HALF_PI_U;

    // perimeter divider geometry
    localparam int DIV_NW  = 36;
    localparam int DIV_DW  = 17;
    localparam int DIV_BPS = 4;
    localparam int DIV_ST  = DIV_NW / DIV_BPS;

    // configuration register indexes
    localparam logic [2:0] CFG_CAR_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_REAR_OVH   = 3'd1;
    localparam logic [2:0] CFG_WHEELBASE  = 3'd2;
    localparam logic [2:0] CFG_TTC_THRESH = 3'd3;
    localparam logic [2:0] CFG_START_ANG  = 3'd4;
    localparam logic [2:0] CFG_ANG_STEP   = 3'd5;
    localparam logic [2:0] CFG_BEAM_COUNT = 3'd6;

    typedef struct packed {
        logic               brake;
        logic [11:0]        idx;
        logic               bad;
    } t_res;

endpackage

// File: rtl/ltte_trig_rom.sv
`timescale 1ns / 1ps
module ltte_trig_rom #(
    parameter int DEPTH = ltte_pkg::TRIG_DEPTH_DEF,
    parameter int KW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [KW-1:0] i_k,
    output logic [16:0]   o_sin,
    output logic [16:0]   o_cos
);
    import ltte_pkg::*;

    logic [16:0] w_tab [0:DEPTH];
    logic [16:0] r_sin;
    logic [16:0] r_cos;
    logic [KW-1:0] w_kc;

    // sine in q16 from an angle in q30, taylor series to the x^13 term
    for (genvar g = 0; g <= DEPTH; g++) begin : g_tab
        localparam longint X  = (longint'(g) * HALF_PI_Q30) / DEPTH;
        localparam longint T1 = ((((X  * X) >>> 30) * X) >>> 30) / 6;
        localparam longint T2 = ((((T1 * X) >>> 30) * X) >>> 30) / 20;
        localparam longint T3 = ((((T2 * X) >>> 30) * X) >>> 30) / 42;
        localparam longint T4 = ((((T3 * X) >>> 30) * X) >>> 30) / 72;
        localparam longint T5 = ((((T4 * X) >>> 30) * X) >>> 30) / 110;
        localparam longint T6 = ((((T5 * X) >>> 30) * X) >>> 30) / 156;
        localparam longint S0 = X - T1 + T2 - T3 + T4 - T5 + T6;
        localparam longint S1 = (S0 < 0) ? 64'sd0 :
                                (S0 > (64'sd1 <<< 30)) ? (64'sd1 <<< 30) : S0;
        localparam longint S2 = (S1 + 8192) >>> 14;
        localparam logic [16:0] Q = (S2 > 65536) ? 17'd65536 : 17'(S2);
        assign w_tab[g] = Q;
    end

    assign w_kc = KW'(DEPTH - int'(i_k));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= w_tab[i_k];
            r_cos <= w_tab[w_kc];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
endmodule

// File: rtl/ltte_angle.sv
`timescale 1ns / 1ps
module ltte_angle #(
    parameter int DEPTH = ltte_pkg::TRIG_DEPTH_DEF,
    parameter int KW    = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [11:0]        i_idx,
    input  logic signed [18:0] i_start,
    input  logic [15:0]        i_step,
    output logic [KW-1:0]      o_k,
    output logic               o_front
);
    import ltte_pkg::*;

    localparam int PW = 17 + KW;

    logic [29:0]   r_a1, r_a2;
    logic [11:0]   r_q2;
    logic [19:0]   r_r3;
    logic [PW-1:0] r_p4, r_p5;
    logic          r_f4, r_f5, r_f6;
    logic [KW:0]   r_q5;
    logic [KW-1:0] r_k6;

    logic signed [30:0] w_a;
    logic [59:0]        w_m1;
    logic [19:0]        w_r, w_u, w_v;
    logic               w_front;
    logic [PW+31:0]     w_m2;
    logic [PW-1:0]      w_rem;
    logic [KW:0]        w_k;

    always_comb begin
        // offset by a full turn so the sum is never negative
        w_a  = 31'(i_start) + 31'(TWO_PI_U) + $signed({3'b0, 28'(i_idx * i_step)});
        w_m1 = 60'(r_a1) * 60'(RECIP_TWO_PI);
        w_r  = (r_r3 >= 20'(TWO_PI_U)) ? r_r3 - 20'(TWO_PI_U) : r_r3;
        w_u  = (w_r >= 20'(PI_U)) ? 20'(TWO_PI_U) - w_r : w_r;
        w_front = w_u <= 20'(HALF_PI_U);
        w_v  = w_front ? w_u : 20'(PI_U) - w_u;
        w_m2 = (PW+32)'(r_p4) * (PW+32)'(RECIP_HALF_PI);
        w_rem = r_p5 - PW'(r_q5 * HALF_PI_U);
        w_k  = (w_rem >= PW'(HALF_PI_U)) ? r_q5 + 1'b1 : r_q5;
        if (int'(w_k) > DEPTH) w_k = (KW+1)'(DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1 <= w_a[29:0];
            r_a2 <= r_a1;
            r_q2 <= w_m1[RECIP_SHIFT +: 12];
            r_r3 <= 20'(r_a2 - 30'(r_q2 * TWO_PI_U));
            r_p4 <= PW'(w_v[16:0] * DEPTH);
            r_f4 <= w_front;
            r_p5 <= r_p4;
            r_q5 <= w_m2[RECIP_SHIFT +: KW+1];
            r_f5 <= r_f4;
            r_k6 <= w_k[KW-1:0];
            r_f6 <= r_f5;
        end
    end

    assign o_k     = r_k6;
    assign o_front = r_f6;
endmodule

// File: rtl/ltte_div.sv
`timescale 1ns / 1ps
module ltte_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [ltte_pkg::DIV_NW-1:0]   i_num,
    input  logic [ltte_pkg::DIV_DW-1:0]   i_den,
    output logic [31:0]                   o_quot
);
    import ltte_pkg::*;

    logic [DIV_DW-1:0] r_rem [0:DIV_ST-1];
    logic [DIV_NW-1:0] r_num [0:DIV_ST-1];
    logic [DIV_NW-1:0] r_quo [0:DIV_ST-1];
    logic [DIV_DW-1:0] r_den [0:DIV_ST-1];
    logic              r_zero [0:DIV_ST-1];

    logic [DIV_DW-1:0] n_rem [0:DIV_ST-1];
    logic [DIV_NW-1:0] n_num [0:DIV_ST-1];
    logic [DIV_NW-1:0] n_quo [0:DIV_ST-1];

    always_comb begin
        logic [DIV_DW-1:0] v_rem;
        logic [DIV_NW-1:0] v_num;
        logic [DIV_NW-1:0] v_quo;
        logic [DIV_DW-1:0] v_den;
        logic [DIV_DW:0]   v_t;
        for (int s = 0; s < DIV_ST; s++) begin
            if (s == 0) begin
                v_rem = '0;
                v_num = i_num;
                v_quo = '0;
                v_den = i_den;
            end else begin
                v_rem = r_rem[s-1];
                v_num = r_num[s-1];
                v_quo = r_quo[s-1];
                v_den = r_den[s-1];
            end
            // restoring steps, one quotient bit each
            for (int b = 0; b < DIV_BPS; b++) begin
                v_t   = {v_rem, v_num[DIV_NW-1]};
                v_num = {v_num[DIV_NW-2:0], 1'b0};
                if (v_t >= {1'b0, v_den}) begin
                    v_t   = v_t - {1'b0, v_den};
                    v_quo = {v_quo[DIV_NW-2:0], 1'b1};
                end else begin
                    v_quo = {v_quo[DIV_NW-2:0], 1'b0};
                end
                v_rem = v_t[DIV_DW-1:0];
            end
            n_rem[s] = v_rem;
            n_num[s] = v_num;
            n_quo[s] = v_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_ST; s++) begin
                r_rem[s] <= n_rem[s];
                r_num[s] <= n_num[s];
                r_quo[s] <= n_quo[s];
                r_den[s]  <= (s == 0) ? i_den : r_den[s-1];
                r_zero[s] <= (s == 0) ? (i_den == '0) : r_zero[s-1];
            end
        end
    end

    // zero divisor or overflow saturates to the cap
    assign o_quot = (r_zero[DIV_ST-1] || (|r_quo[DIV_ST-1][DIV_NW-1:32]))
                  ? 32'hFFFF_FFFF : r_quo[DIV_ST-1][31:0];
endmodule

// File: rtl/lidar_ttc_emergency_brake.sv
`timescale 1ns / 1ps
// throughput: one beam per cycle while o_stall is low; every stage, the two perimeter dividers included,
//   is fully pipelined (the dividers retire 4 quotient bits per stage over 9 stages)
// reset: synchronous active-low; clears valids and loads the register defaults,
//   the sine table is constant and needs no fill
module lidar_ttc_emergency_brake #(
    parameter int MAX_BEAMS        = ltte_pkg::MAX_BEAMS_DEF,
    parameter int TRIG_TABLE_DEPTH = ltte_pkg::TRIG_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // beam input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [11:0]        i_beam_index,
    input  logic [15:0]        i_range_mm,
    input  logic signed [15:0] i_speed_mm_s,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_brake,
    output logic [11:0]        o_beam_echo,
    output logic               o_index_bad,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [18:0]        i_cfg_data
);
    import ltte_pkg::*;

    localparam int KW     = $clog2(TRIG_TABLE_DEPTH + 1);
    localparam int ST_ROM = 6;              // sideband slot aligned with the rom output
    localparam int ST_DIV = ST_ROM + 1;     // slot entering the dividers
    localparam int NSB    = ST_DIV + DIV_ST;
    localparam int NV     = NSB + 3;

    typedef struct packed {
        logic [11:0]        idx;
        logic [15:0]        range;
        logic signed [15:0] speed;
        logic               bad;
        logic               go;
        logic signed [33:0] clos;
    } t_side;

    // configuration registers
    logic [11:0]        r_car_width;
    logic [11:0]        r_rear_ovh;
    logic [11:0]        r_wheelbase;
    logic [15:0]        r_ttc_thresh;
    logic signed [18:0] r_start_ang;
    logic [15:0]        r_ang_step;
    logic [12:0]        r_beam_count;

    // pipeline control
    logic          w_en;
    logic [NV-1:0] r_v;
    t_side         r_sb [0:NSB-1];
    t_side         w_in;
    t_side         w_sb7;
    logic          r_front7;

    logic [KW-1:0] w_k;
    logic          w_front;
    logic [16:0]   w_sin, w_cos;
    logic [11:0]   w_ext;
    logic [31:0]   w_side, w_end;
    logic [31:0]   w_perim;
    logic [31:0]   w_cnt_lim;

    // late stages
    logic signed [33:0] r_d, r_clos_p;
    logic               r_go_p;
    logic [11:0]        r_idx_p, r_idx_q;
    logic               r_bad_p, r_bad_q;
    logic [50:0]        r_lhs, r_rhs;
    logic               r_neg, r_nz, r_go_q;
    t_res               r_res;

    logic signed [33:0] w_dd, w_cc;

    // output register and skid stage
    logic r_out_v, r_skid_v;
    t_res r_out, r_skid;
    logic w_out_free;

    assign w_en    = !r_skid_v;
    assign o_stall = r_skid_v;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_cnt_lim = (32'(r_beam_count) > 32'(MAX_BEAMS)) ? 32'(MAX_BEAMS) : 32'(r_beam_count);
        w_in.idx   = i_beam_index;
        w_in.range = i_range_mm;
        w_in.speed = i_speed_mm_s;
        w_in.bad   = 32'(i_beam_index) >= w_cnt_lim;
        w_in.go    = !w_in.bad && (i_speed_mm_s != 16'sd0);
        w_in.clos  = '0;
    end

    ltte_angle #(.DEPTH(TRIG_TABLE_DEPTH), .KW(KW)) u_angle (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_idx   (i_beam_index),
        .i_start (r_start_ang),
        .i_step  (r_ang_step),
        .o_k     (w_k),
        .o_front (w_front)
    );

    ltte_trig_rom #(.DEPTH(TRIG_TABLE_DEPTH), .KW(KW)) u_rom (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_k   (w_k),
        .o_sin (w_sin),
        .o_cos (w_cos)
    );

    // closing speed and body extent along the beam, from the rom stage
    always_comb begin
        logic signed [17:0] v_c;
        v_c = r_front7 ? $signed({1'b0, w_cos}) : -$signed({1'b0, w_cos});
        w_sb7      = r_sb[ST_ROM];
        w_sb7.clos = 34'(r_sb[ST_ROM].speed * v_c);
        if (r_front7) w_ext = (r_wheelbase >= r_rear_ovh) ? r_wheelbase - r_rear_ovh : 12'd0;
        else          w_ext = r_rear_ovh;
    end

    // half width over sine
    ltte_div u_div_side (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  ({1'b0, r_car_width, 23'b0}),
        .i_den  (w_sin),
        .o_quot (w_side)
    );

    // front or rear extent over cosine
    ltte_div u_div_end (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  ({w_ext, 24'b0}),
        .i_den  (w_cos),
        .o_quot (w_end)
    );

    assign w_perim = (w_side < w_end) ? w_side : w_end;

    // sign fold so the ttc test is done on a positive closing speed
    assign w_dd = (r_clos_p > 34'sd0) ? r_d : -r_d;
    assign w_cc = (r_clos_p < 34'sd0) ? -r_clos_p : r_clos_p;

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car_width  <= 12'd203;
            r_rear_ovh   <= 12'd275;
            r_wheelbase  <= 12'd330;
            r_ttc_thresh <= 16'd200;
            r_start_ang  <= -19'sd154415;
            r_ang_step   <= 16'd286;
            r_beam_count <= 13'd1080;
            r_v          <= '0;
            r_out_v      <= 1'b0;
            r_skid_v     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CAR_WIDTH:  r_car_width  <= i_cfg_data[11:0];
                    CFG_REAR_OVH:   r_rear_ovh   <= i_cfg_data[11:0];
                    CFG_WHEELBASE:  r_wheelbase  <= i_cfg_data[11:0];
                    CFG_TTC_THRESH: r_ttc_thresh <= i_cfg_data[15:0];
                    CFG_START_ANG:  r_start_ang  <= $signed(i_cfg_data);
                    CFG_ANG_STEP:   r_ang_step   <= i_cfg_data[15:0];
                    CFG_BEAM_COUNT: r_beam_count <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (w_en) begin
                r_v <= {r_v[NV-2:0], i_valid};
            end
            // hand the last stage to the output register, or park it in the skid stage
            if (w_out_free) begin
                if (r_skid_v) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= w_en && r_v[NV-1];
                end
            end else if (w_en && r_v[NV-1]) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    assign w_out_free = !r_out_v || !i_stall;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NSB; i++) begin
                if (i == 0)           r_sb[i] <= w_in;
                else if (i == ST_DIV) r_sb[i] <= w_sb7;
                else                  r_sb[i] <= r_sb[i-1];
            end
            r_front7 <= w_front;
            // distance left before contact, q8 mm
            r_d      <= $signed({10'b0, r_sb[NSB-1].range, 8'b0}) - $signed({2'b0, w_perim});
            r_clos_p <= r_sb[NSB-1].clos;
            r_go_p   <= r_sb[NSB-1].go;
            r_idx_p  <= r_sb[NSB-1].idx;
            r_bad_p  <= r_sb[NSB-1].bad;
            // cross-multiplied ttc compare operands
            r_lhs  <= 51'(w_dd[32:0]) * 51'(256000);
            r_rhs  <= 51'(r_ttc_thresh) * 51'(w_cc[31:0]);
            r_neg  <= w_dd < 34'sd0;
            r_nz   <= r_clos_p != 34'sd0;
            r_go_q <= r_go_p;
            r_idx_q <= r_idx_p;
            r_bad_q <= r_bad_p;
            r_res.brake <= r_go_q && r_nz && !r_neg && (r_lhs < r_rhs);
            r_res.idx   <= r_idx_q;
            r_res.bad   <= r_bad_q;
        end
        if (w_out_free) begin
            r_out <= r_skid_v ? r_skid : r_res;
        end else if (w_en && r_v[NV-1]) begin
            r_skid <= r_res;
        end
    end

    assign o_valid     = r_out_v;
    assign o_brake     = r_out.brake;
    assign o_beam_echo = r_out.idx;
    assign o_index_bad = r_out.bad;
endmodule

// File: verif/lidar_ttc_emergency_brake_test.sv
`timescale 1ns / 1ps
module lidar_ttc_emergency_brake_test;
    import ltte_pkg::*;

    localparam int     DEPTH      = 1024;
    localparam int     BEAM_LIMIT = 4096;
    localparam longint CAP        = 64'd4294967295;
    localparam int     CYCLE_LIMIT = 300000;
    localparam int     DRAIN_WAIT = 30;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    // beam channel
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [11:0]        i_beam_index = '0;
    logic [15:0]        i_range_mm = '0;
    logic signed [15:0] i_speed_mm_s = '0;
    // result channel
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_brake;
    logic [11:0]        o_beam_echo;
    logic               o_index_bad;
    // register write channel
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [18:0]        i_cfg_data = '0;

    lidar_ttc_emergency_brake uut (.*);

    typedef struct {
        logic        brake;
        logic [11:0] echo;
        logic        bad;
    } verdict_t;

    // directed stimulus; typed verdict used only when known is set
    typedef struct {
        logic [11:0] idx;
        logic [15:0] rng;
        logic [15:0] spd;
        bit          known;
        logic        brake;
        logic        bad;
    } beam_row_t;

    verdict_t pending_q[$];
    longint   sine_rom[0:DEPTH];
    int       errors = 0;
    int       cycles = 0;

    // local copy of the register file
    longint width_mm, rear_mm, base_mm, thresh_ms, start_ang, step_ang, beams;

    // traffic shaping: 0 none, 1 sender gaps, 2 receiver stalls, 3 both
    int idle_mode = 0;
    bit hold_go = 1'b0;
    bit hold_on = 1'b0;

    function automatic longint trig_entry(input longint k);
        longint x, term, sum;
        x = (k * HALF_PI_Q30) / DEPTH;
        term = x;
        sum = x;
        for (int n = 1; n <= 6; n++) begin
            term = (((term * x) >>> 30) * x) >>> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
        sum = (sum + 8192) >>> 14;
        return (sum > 65536) ? 65536 : sum;
    endfunction

    function automatic longint sat_div(input longint num, input longint den);
        longint q;
        if (den <= 0) return CAP;
        q = num / den;
        return (q > CAP) ? CAP : q;
    endfunction

    // expected verdict for one beam under the current register values
    function automatic verdict_t judge_beam(input logic [11:0] idx, input logic [15:0] rng,
                                            input logic [15:0] spd);
        verdict_t v;
        longint   lim, a, u, f, k, s, c, ext, side, tip, perim, d, clos, dd, cc, speed;
        bit       front;
        lim = (beams > BEAM_LIMIT) ? BEAM_LIMIT : beams;
        speed = longint'($signed(spd));
        v.echo = idx;
        v.bad = (longint'(idx) >= lim);
        v.brake = 1'b0;
        if (!v.bad && speed != 0) begin
            a = start_ang + longint'(idx) * step_ang;
            a = a % TWO_PI_U;
            if (a < 0) a += TWO_PI_U;
            if (a >= PI_U) a -= TWO_PI_U;
            u = (a < 0) ? -a : a;
            front = (u <= HALF_PI_U);
            f = front ? u : PI_U - u;
            k = (f * DEPTH) / HALF_PI_U;
            if (k > DEPTH) k = DEPTH;
            s = sine_rom[k];
            c = sine_rom[DEPTH - k];
            ext = front ? base_mm - rear_mm : rear_mm;
            if (ext < 0) ext = 0;
            side = sat_div(width_mm * (64'sd1 <<< 23), s);
            tip = sat_div(ext * (64'sd1 <<< 24), c);
            perim = (side < tip) ? side : tip;
            d = longint'(rng) * 256 - perim;
            clos = speed * (front ? c : -c);
            if (clos != 0) begin
                dd = (clos > 0) ? d : -d;
                cc = (clos > 0) ? clos : -clos;
                v.brake = (dd >= 0) && (dd * 256000 < thresh_ms * cc);
            end
        end
        return v;
    endfunction

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // long receiver hold-off so the pipe fills and backs up into the input
    initial begin
        wait (hold_go);
        @(negedge i_clk);
        hold_on = 1'b1;
        repeat (400) @(posedge i_clk);
        @(negedge i_clk);
        hold_on = 1'b0;
    end

    // result side: check each transaction and pick the next stall value
    always @(posedge i_clk) begin
        verdict_t want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result for beam %0d", o_beam_echo));
            end else begin
                want = pending_q.pop_front();
                if (o_beam_echo !== want.echo)
                    report($sformatf("beam_echo %0d, want %0d", o_beam_echo, want.echo));
                if (o_index_bad !== want.bad)
                    report($sformatf("index_bad %b, want %b (beam %0d)",
                                     o_index_bad, want.bad, want.echo));
                if (o_brake !== want.brake)
                    report($sformatf("brake %b, want %b (beam %0d)",
                                     o_brake, want.brake, want.echo));
            end
        end
        if (hold_on) begin
            i_stall <= 1'b1;
        end else begin
            case (idle_mode)
                2:       i_stall <= ($urandom_range(99) < 49);
                3:       i_stall <= ($urandom_range(99) < 37);
                default: i_stall <= 1'b0;
            endcase
        end
    end

    // offer one beam, hold it until the block takes it, then log the verdict
    task automatic push_beam(input logic [11:0] idx, input logic [15:0] rng,
                             input logic [15:0] spd, input verdict_t want);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 49 : (idle_mode == 3) ? 37 : 0;
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_beam_index <= idx;
        i_range_mm <= rng;
        i_speed_mm_s <= spd;
        do @(posedge i_clk); while (o_stall);
        pending_q = {pending_q, want};
    endtask

    // wait until the pipe is empty before touching registers
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input longint val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 19'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CAR_WIDTH:  width_mm = val & 12'hFFF;
            CFG_REAR_OVH:   rear_mm = val & 12'hFFF;
            CFG_WHEELBASE:  base_mm = val & 12'hFFF;
            CFG_TTC_THRESH: thresh_ms = val & 16'hFFFF;
            CFG_START_ANG:  start_ang = val;
            CFG_ANG_STEP:   step_ang = val & 16'hFFFF;
            default:        beams = val & 13'h1FFF;
        endcase
    endtask

    task automatic load_regs(input longint w, input longint r, input longint b,
                             input longint t, input longint sa, input longint st,
                             input longint n);
        reg_write(CFG_CAR_WIDTH, w);
        reg_write(CFG_REAR_OVH, r);
        reg_write(CFG_WHEELBASE, b);
        reg_write(CFG_TTC_THRESH, t);
        reg_write(CFG_START_ANG, sa);
        reg_write(CFG_ANG_STEP, st);
        reg_write(CFG_BEAM_COUNT, n);
    endtask

    // random beams, mostly in range and mostly near the car so braking happens
    task automatic random_beams(input int count);
        logic [11:0] idx;
        logic [15:0] rng;
        logic [15:0] spd;
        longint      lim;
        for (int i = 0; i < count; i++) begin
            lim = (beams > BEAM_LIMIT) ? BEAM_LIMIT : beams;
            if ($urandom_range(99) < 75 && lim > 0)
                idx = 12'($urandom_range(0, int'(lim) - 1));
            else
                idx = 12'($urandom);
            rng = ($urandom_range(1)) ? 16'($urandom_range(0, 1500)) : 16'($urandom);
            case ($urandom_range(3))
                0:       spd = 16'($urandom_range(0, 600)) - 16'd300;
                1:       spd = 16'd0;
                default: spd = 16'($urandom);
            endcase
            push_beam(idx, rng, spd, judge_beam(idx, rng, spd));
        end
    endtask

    beam_row_t directed[] = '{
        // zero speed never brakes
        '{12'd0,    16'd0,     16'h0000, 1'b1, 1'b0, 1'b0},
        '{12'd540,  16'd0,     16'h0000, 1'b1, 1'b0, 1'b0},
        // index past the beam count
        '{12'd4095, 16'd65535, 16'h7FFF, 1'b1, 1'b0, 1'b1},
        '{12'd1080, 16'd100,   16'h8000, 1'b1, 1'b0, 1'b1},
        '{12'd2048, 16'd0,     16'h0001, 1'b1, 1'b0, 1'b1},
        // last valid beam and straight ahead
        '{12'd1079, 16'd300,   16'h7FFF, 1'b0, 1'b0, 1'b0},
        '{12'd540,  16'd0,     16'h7FFF, 1'b0, 1'b0, 1'b0},
        '{12'd540,  16'd100,   16'h7FFF, 1'b0, 1'b0, 1'b0},
        '{12'd540,  16'd250,   16'd1000, 1'b0, 1'b0, 1'b0},
        '{12'd540,  16'd65535, 16'h7FFF, 1'b0, 1'b0, 1'b0},
        '{12'd540,  16'd120,   16'h8000, 1'b0, 1'b0, 1'b0},
        '{12'd540,  16'd130,   16'hFFFF, 1'b0, 1'b0, 1'b0},
        '{12'd540,  16'd130,   16'h0001, 1'b0, 1'b0, 1'b0},
        // sides and behind
        '{12'd180,  16'd150,   16'd2000, 1'b0, 1'b0, 1'b0},
        '{12'd900,  16'd150,   16'hF000, 1'b0, 1'b0, 1'b0},
        '{12'd0,    16'd400,   16'h8000, 1'b0, 1'b0, 1'b0},
        '{12'd0,    16'd0,     16'h7FFF, 1'b0, 1'b0, 1'b0},
        '{12'd360,  16'd110,   16'd500,  1'b0, 1'b0, 1'b0},
        '{12'd720,  16'd110,   16'hFE00, 1'b0, 1'b0, 1'b0},
        '{12'd2730, 16'hAAAA,  16'h5555, 1'b1, 1'b0, 1'b1}
    };

    initial begin
        verdict_t want;
        for (int k = 0; k <= DEPTH; k++) sine_rom[k] = trig_entry(k);
        width_mm = 203;
        rear_mm = 275;
        base_mm = 330;
        thresh_ms = 200;
        start_ang = -154415;
        step_ang = 286;
        beams = 1080;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part against the reset register values
        foreach (directed[n]) begin
            want = judge_beam(directed[n].idx, directed[n].rng, directed[n].spd);
            if (directed[n].known) begin
                want.brake = directed[n].brake;
                want.bad = directed[n].bad;
            end
            push_beam(directed[n].idx, directed[n].rng, directed[n].spd, want);
        end

        // free-running beams at the defaults, pipe backed up by a long hold
        hold_go = 1'b1;
        random_beams(120);
        drain();

        // extremes: widest car, negative front extent, huge step wraps angles
        load_regs(4095, 4095, 0, 65535, -205887, 65535, 4096);
        idle_mode = 1;
        random_beams(110);
        drain();

        // minimums: no body, zero threshold, single beam
        load_regs(0, 0, 0, 0, 205887, 0, 1);
        idle_mode = 2;
        random_beams(60);
        drain();

        // beams straddling the quarter-turn edge
        load_regs(300, 400, 2000, 3000, HALF_PI_U - 8, 1, 16);
        idle_mode = 3;
        random_beams(100);
        drain();

        // zero-angle beam and sensor-sized car
        load_regs(180, 100, 400, 1000, -2000, 40, 100);
        idle_mode = 0;
        random_beams(100);
        drain();

        // random register settings, cycling through the traffic modes
        for (int p = 0; p < 4; p++) begin
            load_regs($urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 65535),
                      longint'($urandom_range(0, 411774)) - 205887,
                      $urandom_range(0, 65535), $urandom_range(1, 4096));
            idle_mode = p;
            random_beams(90);
            drain();
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/ltte_pkg.sv
rtl/ltte_trig_rom.sv
rtl/ltte_angle.sv
rtl/ltte_div.sv
rtl/lidar_ttc_emergency_brake.sv
verif/lidar_ttc_emergency_brake_test.sv
